FILE: hdl/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, default parameter values and the sequencer state type.
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COLOR_BITS     = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_X,
      ST_WAIT_X,
      ST_LOAD_Y,
      ST_WAIT_Y,
      ST_DRAW
   } state_type;

endpackage

FILE: hdl/dda_divider.sv
// ----------------------------------------------------------------------------
// DDA increment divider
// Restoring divider, one quotient bit per cycle. Computes
// floor((dividend << FRAC_BITS) / divisor) for dividend <= divisor, so the
// quotient needs FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module dda_divider #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0] divisor,
   output logic                  done,
   output logic [FRAC_BITS:0]    quotient
);

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [FRAC_BITS:0]    quo_ff, quo_in;
   logic [COORD_BITS-1:0] div_ff, div_in;
   logic                  ge;
   logic [COORD_BITS:0]   rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      ge      = rem_ff >= {1'b0, div_ff};
      rem_sub = ge ? (rem_ff - {1'b0, div_ff}) : rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, dividend};
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below divisor, so the shift never overflows
         rem_in = {rem_sub[COORD_BITS-1:0], 1'b0};
         quo_in = {quo_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Turns one line word into a stream of pixel words along the line.
// ----------------------------------------------------------------------------
// One line word is taken when the block is idle. The x and y increments are
// computed one after the other on a single bit-serial divider. Each division
// is started in its load state and its increment is taken in its wait state
// once the divider signals done. After that, one pixel word leaves per cycle
// while the output is taken. A line gives steps pixel words, where steps is
// the larger of the absolute x and y deltas. The end point is not drawn, a
// zero-length line gives no pixel, and the final pixel carries rsp_tlast.
// A finished pixel may still wait in the output register while the next
// line is taken.
module dda_line_rasterizer #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y, red, green, blue
   input  logic [((4*COORD_BITS+3*dda_pkg::COLOR_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
   output logic [((2*COORD_BITS+3*dda_pkg::COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);

   import dda_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int ACC    = COORD_BITS + FRAC_BITS;
   localparam int RSP_W  = ((2*COORD_BITS+3*COLOR_BITS+7)/8)*8;

   state_type state_ff, state_in;

   logic [C-1:0]          s_x, s_y, e_x, e_y;
   logic [COLOR_BITS-1:0] c_r, c_g, c_b;
   logic [C-1:0]          adx, ady, steps;

   logic [C-1:0]          adx_ff, adx_in, ady_ff, ady_in, steps_ff, steps_in;
   logic                  neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [COLOR_BITS-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [ACC-1:0]        acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [ACC-1:0]        step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [C-1:0]          left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [C-1:0]          pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [COLOR_BITS-1:0] pix_r_ff, pix_r_in, pix_g_ff, pix_g_in, pix_b_ff, pix_b_in;

   logic                  div_start, div_done;
   logic [C-1:0]          div_dividend;
   logic [FRAC_BITS:0]    div_quotient;
   logic [ACC-1:0]        quo_ext;

   assign s_x = req_tdata[C-1:0];
   assign s_y = req_tdata[2*C-1:C];
   assign e_x = req_tdata[3*C-1:2*C];
   assign e_y = req_tdata[4*C-1:3*C];
   assign c_r = req_tdata[4*C+COLOR_BITS-1:4*C];
   assign c_g = req_tdata[4*C+2*COLOR_BITS-1:4*C+COLOR_BITS];
   assign c_b = req_tdata[4*C+3*COLOR_BITS-1:4*C+2*COLOR_BITS];

   assign adx   = (e_x >= s_x) ? (e_x - s_x) : (s_x - e_x);
   assign ady   = (e_y >= s_y) ? (e_y - s_y) : (s_y - e_y);
   assign steps = (adx > ady) ? adx : ady;

   assign quo_ext = ACC'(div_quotient);

   dda_divider #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (steps_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      steps_in     = steps_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_r_in     = pix_r_ff;
      pix_g_in     = pix_g_ff;
      pix_b_in     = pix_b_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = adx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               adx_in   = adx;
               ady_in   = ady;
               steps_in = steps;
               neg_x_in = e_x < s_x;
               neg_y_in = e_y < s_y;
               red_in   = c_r;
               green_in = c_g;
               blue_in  = c_b;
               acc_x_in = {s_x, {FRAC_BITS{1'b0}}};
               acc_y_in = {s_y, {FRAC_BITS{1'b0}}};
               left_in  = steps;
               if (steps != '0) begin
                  state_in = ST_LOAD_X;
               end
            end
         end
         ST_LOAD_X: begin
            div_start = 1'b1;
            state_in  = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (div_done) begin
               step_x_in = neg_x_ff ? (ACC'(0) - quo_ext) : quo_ext;
               state_in  = ST_LOAD_Y;
            end
         end
         ST_LOAD_Y: begin
            div_start    = 1'b1;
            div_dividend = ady_ff;
            state_in     = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            div_dividend = ady_ff;
            if (div_done) begin
               step_y_in = neg_y_ff ? (ACC'(0) - quo_ext) : quo_ext;
               state_in  = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = left_ff == C'(1);
               pix_x_in     = acc_x_ff[ACC-1:FRAC_BITS];
               pix_y_in     = acc_y_ff[ACC-1:FRAC_BITS];
               pix_r_in     = red_ff;
               pix_g_in     = green_ff;
               pix_b_in     = blue_ff;
               acc_x_in     = acc_x_ff + step_x_ff;
               acc_y_in     = acc_y_ff + step_y_ff;
               left_in      = left_ff - C'(1);
               if (left_ff == C'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      steps_ff    <= steps_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      left_ff     <= left_in;
      rsp_last_ff <= rsp_last_in;
      pix_x_ff    <= pix_x_in;
      pix_y_ff    <= pix_y_in;
      pix_r_ff    <= pix_r_in;
      pix_g_ff    <= pix_g_in;
      pix_b_ff    <= pix_b_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({pix_b_ff, pix_g_ff, pix_r_ff, pix_y_ff, pix_x_ff});

endmodule
